FILE: design/ppc_pkg.sv
// shared types and constants of the pi position controller
package ppc_pkg;

  localparam int unsigned EncoderMaxDefault = 9000;
  localparam int unsigned DeadbandDefault   = 20;

  localparam int unsigned EncW   = 16;
  localparam int unsigned SldW   = 8;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned DirW   = 2;
  localparam int unsigned PerrW  = 16;
  localparam int unsigned ErrW   = 17;  // internal error, one guard bit
  localparam int unsigned MagW   = 16;  // magnitude of the error
  localparam int unsigned DivW   = 10;  // divisor width, covers 1000 and 255
  localparam int unsigned CntW   = 4;   // one divider step per dividend bit
  localparam int unsigned IntW   = 32;
  localparam int unsigned ProdW  = 41;  // 9-bit signed gain times 32-bit integral
  localparam int unsigned DrvW   = 42;

  localparam logic [CfgW-1:0] KpInverseReset    = 8'd3;
  localparam logic [CfgW-1:0] IntegralGainReset = 8'd3;
  localparam logic [DivW-1:0] IntegralDivisor   = 10'd1000;
  localparam logic [6:0]      RefGain           = 7'd90;
  localparam logic [8:0]      SliderCenter      = 9'd100;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  typedef enum logic {
    CFG_KP_INVERSE    = 1'b0,
    CFG_INTEGRAL_GAIN = 1'b1
  } cfg_idx_e;

  typedef enum logic [DirW-1:0] {
    DIR_NEUTRAL = 2'd0,
    DIR_LEFT    = 2'd1,
    DIR_RIGHT   = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_I,
    ST_INTEG,
    ST_DIV_P,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_e;

endpackage

FILE: design/ppc_if.sv
// valid/ready channel interfaces for samples, results and register writes
interface ppc_in_if
  import ppc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            opcode;
  logic [EncW-1:0] encoder_count;
  logic [SldW-1:0] slider_position;

  modport source (output valid, opcode, encoder_count, slider_position, input ready);
  modport sink   (input valid, opcode, encoder_count, slider_position, output ready);
endinterface

interface ppc_out_if
  import ppc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [SpeedW-1:0]        motor_speed;
  logic [DirW-1:0]          motor_direction;
  logic signed [PerrW-1:0]  position_error;

  modport source (output valid, motor_speed, motor_direction, position_error, input ready);
  modport sink   (input valid, motor_speed, motor_direction, position_error, output ready);
endinterface

interface ppc_cfg_if
  import ppc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            index;
  logic [CfgW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/pi_position_controller_unit.sv
// pi position controller: sequencer around one shared restoring divider
// A sample runs through one restoring divider, one quotient bit per cycle, used twice: first
// error by 1000 for the integral, then the integral update, then error by kp_inverse for
// the proportional term, followed by the gain multiply, the final sum and the result
// hand-off. With kp_inverse at zero the second division is skipped. The sample channel is
// ready again in the same cycle that the result shows. A clear opcode goes straight from
// its transfer to the hand-off. The hand-off waits while the output register still
// holds an earlier result; once it is free, the next sample is taken while the new result
// waits for its transfer. Register writes are always accepted and belong in idle periods.
module pi_position_controller_unit
  import ppc_pkg::*;
#(
  parameter int unsigned ENCODER_MAX = EncoderMaxDefault,
  parameter int unsigned DEADBAND    = DeadbandDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppc_in_if.sink    sample_i,
  ppc_out_if.source result_o,
  ppc_cfg_if.sink   cfg_i
);

  localparam logic [EncW-1:0]  EncMax  = EncW'(ENCODER_MAX);
  localparam logic [ErrW-1:0]  DbPos   = ErrW'(DEADBAND);
  localparam logic [ErrW-1:0]  DbNeg   = ErrW'(-$signed(ErrW'(DEADBAND)));
  localparam logic [IntW+1:0]  SatMax  = {3'b000, {(IntW-1){1'b1}}};
  localparam logic [IntW+1:0]  SatMin  = {3'b111, {(IntW-1){1'b0}}};

  state_e state_q, state_d;

  logic [CfgW-1:0] kp_q, kp_d;
  logic [CfgW-1:0] gain_q, gain_d;

  logic signed [IntW-1:0] integral_q, integral_d;
  dir_e                   dir_q, dir_d;

  logic signed [ErrW-1:0] err_q, err_d;
  logic [MagW-1:0]        mag_q, mag_d;
  logic [MagW-1:0]        qsh_q, qsh_d;
  logic [DivW-1:0]        rem_q, rem_d;
  logic [DivW-1:0]        div_q, div_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [ErrW-1:0] prop_q, prop_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [SpeedW-1:0]      speed_q, speed_d;

  logic                   ovalid_q, ovalid_d;
  logic [SpeedW-1:0]      ospeed_q, ospeed_d;
  logic [DirW-1:0]        odir_q, odir_d;
  logic [PerrW-1:0]       operr_q, operr_d;

  // sample front end
  logic [8:0]             sld_diff;
  logic [SldW-1:0]        sld_abs;
  logic [13:0]            ref_val;
  logic [EncW-1:0]        pos_val;
  logic signed [ErrW-1:0] err_in;

  // divider step
  logic [DivW:0]          div_shift;
  logic                   div_ge;
  logic [DivW:0]          div_sub;

  // integral and drive
  logic signed [IntW+1:0] quo_signed;
  logic signed [IntW+1:0] int_sum;
  logic signed [DrvW-1:0] drive;
  logic [SpeedW-1:0]      drive_lo;

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = sample_i.valid && sample_i.ready;
  assign out_xfer = result_o.valid && result_o.ready;

  assign sld_diff = {1'b0, sample_i.slider_position} - SliderCenter;
  assign sld_abs  = sld_diff[8] ? SldW'(-sld_diff) : sld_diff[SldW-1:0];
  assign ref_val  = 14'(sld_abs * RefGain);

  always_comb begin
    priority if (sample_i.encoder_count[EncW-1]) begin
      pos_val = EncMax;
    end else if (sample_i.encoder_count > EncMax) begin
      pos_val = '0;
    end else begin
      pos_val = sample_i.encoder_count;
    end
  end

  assign err_in = $signed({3'b000, ref_val}) - $signed({1'b0, pos_val});

  assign div_shift = {rem_q, qsh_q[MagW-1]};
  assign div_ge    = div_shift >= {1'b0, div_q};
  assign div_sub   = div_shift - {1'b0, div_q};

  // quotient of the first division carries the sign of the error
  assign quo_signed = err_q[ErrW-1] ? -$signed({{(IntW+2-MagW){1'b0}}, qsh_q})
                                    :  $signed({{(IntW+2-MagW){1'b0}}, qsh_q});
  assign int_sum    = $signed({{2{integral_q[IntW-1]}}, integral_q}) + quo_signed;

  assign drive    = $signed({prod_q[ProdW-1], prod_q})
                  + $signed({{(DrvW-ErrW){prop_q[ErrW-1]}}, prop_q});
  assign drive_lo = drive[DrvW-1] ? SpeedW'(-drive[SpeedW-1:0]) : drive[SpeedW-1:0];

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = (state_q == ST_IDLE);

  always_comb begin
    kp_d   = kp_q;
    gain_d = gain_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_KP_INVERSE:    kp_d   = cfg_i.data;
        CFG_INTEGRAL_GAIN: gain_d = cfg_i.data;
        default:           kp_d   = kp_q;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    integral_d = integral_q;
    dir_d      = dir_q;
    err_d      = err_q;
    mag_d      = mag_q;
    qsh_d      = qsh_q;
    rem_d      = rem_q;
    div_d      = div_q;
    cnt_d      = cnt_q;
    prop_d     = prop_q;
    prod_d     = prod_q;
    speed_d    = speed_q;
    ovalid_d   = ovalid_q && !out_xfer;
    ospeed_d   = ospeed_q;
    odir_d     = odir_q;
    operr_d    = operr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (sample_i.opcode == OP_CLEAR) begin
            integral_d = '0;
            speed_d    = '0;
            err_d      = '0;
            state_d    = ST_DONE;
          end else begin
            err_d   = err_in;
            mag_d   = err_in[ErrW-1] ? MagW'(-err_in) : err_in[MagW-1:0];
            qsh_d   = err_in[ErrW-1] ? MagW'(-err_in) : err_in[MagW-1:0];
            rem_d   = '0;
            div_d   = IntegralDivisor;
            cnt_d   = '0;
            state_d = ST_DIV_I;
          end
        end
      end
      ST_DIV_I, ST_DIV_P: begin
        rem_d = div_ge ? div_sub[DivW-1:0] : div_shift[DivW-1:0];
        qsh_d = {qsh_q[MagW-2:0], div_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == {CntW{1'b1}}) begin
          state_d = (state_q == ST_DIV_I) ? ST_INTEG : ST_MUL;
        end
      end
      ST_INTEG: begin
        priority if (int_sum > $signed(SatMax)) begin
          integral_d = {1'b0, {(IntW-1){1'b1}}};
        end else if (int_sum < $signed(SatMin)) begin
          integral_d = {1'b1, {(IntW-1){1'b0}}};
        end else begin
          integral_d = int_sum[IntW-1:0];
        end
        // a zero divisor drops the proportional term
        if (kp_q == '0) begin
          qsh_d   = '0;
          state_d = ST_MUL;
        end else begin
          qsh_d   = mag_q;
          rem_d   = '0;
          div_d   = {{(DivW-CfgW){1'b0}}, kp_q};
          cnt_d   = '0;
          state_d = ST_DIV_P;
        end
      end
      ST_MUL: begin
        prop_d  = err_q[ErrW-1] ? -$signed({1'b0, qsh_q}) : $signed({1'b0, qsh_q});
        prod_d  = ProdW'($signed({1'b0, gain_q}) * integral_q);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        speed_d = drive_lo;
        priority if (err_q > $signed(DbPos)) begin
          dir_d = DIR_LEFT;
        end else if (err_q < $signed(DbNeg)) begin
          dir_d = DIR_RIGHT;
        end else begin
          dir_d = dir_q;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ovalid_q || result_o.ready) begin
          ovalid_d = 1'b1;
          ospeed_d = speed_q;
          odir_d   = dir_q;
          operr_d  = err_q[PerrW-1:0];
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      kp_q       <= KpInverseReset;
      gain_q     <= IntegralGainReset;
      integral_q <= '0;
      dir_q      <= DIR_NEUTRAL;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      kp_q       <= kp_d;
      gain_q     <= gain_d;
      integral_q <= integral_d;
      dir_q      <= dir_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q    <= err_d;
    mag_q    <= mag_d;
    qsh_q    <= qsh_d;
    rem_q    <= rem_d;
    div_q    <= div_d;
    cnt_q    <= cnt_d;
    prop_q   <= prop_d;
    prod_q   <= prod_d;
    speed_q  <= speed_d;
    ospeed_q <= ospeed_d;
    odir_q   <= odir_d;
    operr_q  <= operr_d;
  end

  assign result_o.valid           = ovalid_q;
  assign result_o.motor_speed     = ospeed_q;
  assign result_o.motor_direction = odir_q;
  assign result_o.position_error  = $signed(operr_q);

endmodule

FILE: design/ppc_checker.sv
// port-level assertions for the pi position controller, bound to the top level
module ppc_checker
  import ppc_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [DirW-1:0] out_dir_i
);

  // a result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // the sequencer is busy right after a sample transfer
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample channel ready while a sample is in work");

  // handing off a result returns the sequencer to idle
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result shown while the sequencer is not idle");

  // direction code is neutral, left or right
  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_dir_i != 2'd3)
    else $error("invalid direction code");

endmodule

bind pi_position_controller_unit ppc_checker u_ppc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_dir_i   (result_o.motor_direction)
);

FILE: verif/testbench.sv
// self-checking testbench for the pi position controller unit
module testbench;
  import ppc_pkg::*;

  localparam int EncMax       = int'(EncoderMaxDefault);
  localparam int Deadband     = int'(DeadbandDefault);
  localparam int SettleCycles = 48;
  localparam int ItemsPerSet  = 150;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic [DirW-1:0]   direction;
    logic [PerrW-1:0]  perr;
  } drive_result_t;

  typedef struct packed {
    opcode_e         op;
    logic [EncW-1:0] enc;
    logic [SldW-1:0] sld;
  } sample_t;

  class pi_drive_scoreboard;
    int            kp_div;
    int            ki_gain;
    longint        integral;
    dir_e          drive_dir;
    drive_result_t expected_drives[$];
    int            errors;
    int            samples;
    int            clears;
    int            checked;
    longint        peak_integral;

    function new();
      kp_div        = int'(KpInverseReset);
      ki_gain       = int'(IntegralGainReset);
      integral      = 0;
      drive_dir     = DIR_NEUTRAL;
      errors        = 0;
      samples       = 0;
      clears        = 0;
      checked       = 0;
      peak_integral = 0;
    endfunction

    function void set_gain(cfg_idx_e idx, logic [CfgW-1:0] val);
      if (idx == CFG_KP_INVERSE) kp_div = int'(val);
      else ki_gain = int'(val);
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    // works out the result of one accepted sample and queues it
    function void note_sample(opcode_e op, logic [EncW-1:0] enc, logic [SldW-1:0] sld);
      int            target;
      int            pos;
      int            err;
      longint        drive;
      longint        mag;
      drive_result_t r;
      samples++;
      if (op == OP_CLEAR) begin
        clears++;
        integral    = 0;
        r.speed     = '0;
        r.direction = drive_dir;
        r.perr      = '0;
      end else begin
        target = int'(sld) - 100;
        if (target < 0) target = -target;
        target = target * 90;
        // underflow flag wins over the overrange check
        if (enc[EncW-1]) pos = EncMax;
        else if (int'(enc) > EncMax) pos = 0;
        else pos = int'(enc);
        err = target - pos;
        integral = integral + err / 1000;
        if (integral > 64'sd2147483647) integral = 64'sd2147483647;
        if (integral < -64'sd2147483648) integral = -64'sd2147483648;
        if (integral > peak_integral) peak_integral = integral;
        if (-integral > peak_integral) peak_integral = -integral;
        drive = longint'(ki_gain) * integral;
        if (kp_div != 0) drive = drive + longint'(err / kp_div);
        mag = (drive < 0) ? -drive : drive;
        if (err > Deadband) drive_dir = DIR_LEFT;
        else if (err < -Deadband) drive_dir = DIR_RIGHT;
        r.speed     = mag[SpeedW-1:0];
        r.direction = drive_dir;
        r.perr      = err[PerrW-1:0];
      end
      expected_drives.push_back(r);
    endfunction

    function void check_result(logic [SpeedW-1:0] speed, logic [DirW-1:0] dir_v,
                               logic [PerrW-1:0] perr);
      drive_result_t r;
      if (expected_drives.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: speed %0d dir %0d error %0d",
                   speed, dir_v, $signed(perr));
        return;
      end
      r = expected_drives.pop_front();
      checked++;
      if (speed !== r.speed || dir_v !== r.direction || perr !== r.perr) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch on result %0d: speed exp %0d got %0d, ",
                    "dir exp %0d got %0d, error exp %0d got %0d"},
                   checked, r.speed, speed, r.direction, dir_v,
                   $signed(r.perr), $signed(perr));
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic steady = 1'b0;
  int   stall_left;
  int   gain_sets;

  pi_drive_scoreboard sb = new();

  ppc_in_if  sample_if ();
  ppc_out_if result_if ();
  ppc_cfg_if cfg_if ();

  pi_position_controller_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #8_000_000;
    $display("pi_position_controller_unit verification failed");
    $finish;
  end

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random backpressure, no new stall drawn while steady
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      stall_left      <= 0;
    end else if (stall_left != 0) begin
      result_if.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else begin
      result_if.ready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 30) stall_left <= idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      sb.check_result(result_if.motor_speed, result_if.motor_direction,
                      result_if.position_error);
  end

  // valid stays high into the next call when no gap is drawn
  task automatic send_sample(opcode_e op, logic [EncW-1:0] enc, logic [SldW-1:0] sld);
    int gap;
    sample_if.valid           <= 1'b1;
    sample_if.opcode          <= op;
    sample_if.encoder_count   <= enc;
    sample_if.slider_position <= sld;
    do @(posedge clk_i); while (!sample_if.ready);
    sb.note_sample(op, enc, sld);
    gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_gains(logic [CfgW-1:0] kp, logic [CfgW-1:0] ki);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_KP_INVERSE;
    cfg_if.data  <= kp;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_gain(CFG_KP_INVERSE, kp);
    cfg_if.index <= CFG_INTEGRAL_GAIN;
    cfg_if.data  <= ki;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_gain(CFG_INTEGRAL_GAIN, ki);
    cfg_if.valid <= 1'b0;
    gain_sets++;
  endtask

  // segments hold the slider so the integral can build up
  task automatic run_random(int count);
    int              seg_left;
    int              r;
    int              target;
    int              e;
    logic [SldW-1:0] hold_sld;
    logic [SldW-1:0] sld;
    logic [EncW-1:0] enc;
    opcode_e         op;
    seg_left = 0;
    hold_sld = '0;
    for (int i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        hold_sld = SldW'($urandom_range(0, 255));
        steady   = ($urandom_range(0, 4) == 0);
      end
      seg_left--;
      op  = ($urandom_range(0, 99) < 4) ? OP_CLEAR : OP_TICK;
      sld = ($urandom_range(0, 99) < 75) ? hold_sld : SldW'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 65) enc = EncW'($urandom_range(0, EncMax));
      else if (r < 77) enc = EncW'($urandom_range(EncMax + 1, 32767));
      else if (r < 89) enc = EncW'($urandom_range(32768, 65535));
      else begin
        // land close to the deadband edges
        target = int'(sld) - 100;
        if (target < 0) target = -target;
        target = target * 90;
        e = target + $urandom_range(0, 50) - 25;
        if (e < 0) e = 0;
        if (e > EncMax) e = EncMax;
        enc = e[EncW-1:0];
      end
      send_sample(op, enc, sld);
    end
    sample_if.valid <= 1'b0;
    steady = 1'b0;
  endtask

  sample_t directed[] = '{
    '{OP_CLEAR, 16'hFFFF, 8'd255},
    '{OP_TICK,  16'd0,    8'd0},
    '{OP_TICK,  16'd9000, 8'd255},
    '{OP_TICK,  16'd9001, 8'd100},
    '{OP_TICK,  16'h7FFF, 8'd0},
    '{OP_TICK,  16'h8000, 8'd100},
    '{OP_TICK,  16'hFFFF, 8'd0},
    '{OP_TICK,  16'd20,   8'd100},
    '{OP_TICK,  16'd21,   8'd100},
    '{OP_TICK,  16'd70,   8'd101},
    '{OP_TICK,  16'd69,   8'd101},
    '{OP_TICK,  16'd90,   8'd99},
    '{OP_CLEAR, 16'h0000, 8'd0},
    '{OP_TICK,  16'd0,    8'd255},
    '{OP_TICK,  16'd0,    8'd255},
    '{OP_TICK,  16'd0,    8'd255},
    '{OP_TICK,  16'h5555, 8'h55},
    '{OP_TICK,  16'h2AAA, 8'hAA},
    '{OP_TICK,  16'd8999, 8'd100},
    '{OP_TICK,  16'd8999, 8'd100},
    '{OP_CLEAR, 16'hAAAA, 8'h5A},
    '{OP_TICK,  16'd1,    8'd1}
  };

  initial begin
    gain_sets = 0;
    sample_if.valid           <= 1'b0;
    sample_if.opcode          <= OP_TICK;
    sample_if.encoder_count   <= '0;
    sample_if.slider_position <= '0;
    cfg_if.valid              <= 1'b0;
    cfg_if.index              <= CFG_KP_INVERSE;
    cfg_if.data               <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gains first
    foreach (directed[i]) send_sample(directed[i].op, directed[i].enc, directed[i].sld);
    run_random(ItemsPerSet);

    settle();
    write_gains(8'd255, 8'd255);
    run_random(ItemsPerSet);

    settle();
    write_gains(8'd1, 8'd0);
    run_random(ItemsPerSet);

    // zero divisor drops the proportional term
    settle();
    write_gains(8'd0, 8'd37);
    run_random(ItemsPerSet);

    settle();
    write_gains(8'd1, 8'd255);
    run_random(ItemsPerSet);

    settle();
    write_gains(CfgW'($urandom_range(1, 255)), CfgW'($urandom_range(0, 255)));
    run_random(ItemsPerSet);

    settle();
    $display("%0d samples sent, %0d of them clears; %0d results checked",
             sb.samples, sb.clears, sb.checked);
    $display("%0d gain settings written beyond reset; largest integral magnitude %0d",
             gain_sets, sb.peak_integral);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pi_position_controller_unit verification clean");
    end else begin
      $display("pi_position_controller_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ppc_pkg.sv
design/ppc_if.sv
design/pi_position_controller_unit.sv
design/ppc_checker.sv
verif/testbench.sv
